[rtl/core/hpsc_pkg.sv]
package hpsc_pkg;

    // field widths
    localparam int HEAD_W     = 16;
    localparam int ERR_W      = 18;
    localparam int GAIN_W     = 24;
    localparam int PROD_W     = GAIN_W + ERR_W;
    localparam int SETPT_W    = 9;
    localparam int BAND_W     = 10;
    localparam int LIMIT_W    = 15;
    localparam int SPEED_W    = 16;
    localparam int FRAC_BITS  = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int ACCUM_WIDTH_DEF = 48;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SETPOINT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PREV  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_PREV2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT      = 3'd5;

    // reset values
    localparam logic [SETPT_W-1:0]       SETPT_RST  = 9'd180;
    localparam logic signed [GAIN_W-1:0] GAIN0_RST  = -24'sd261161;
    localparam logic signed [GAIN_W-1:0] GAIN1_RST  = 24'sd425656;
    localparam logic signed [GAIN_W-1:0] GAIN2_RST  = -24'sd173234;
    localparam logic [BAND_W-1:0]        BAND_RST   = 10'd40;
    localparam logic [LIMIT_W-1:0]       LIMIT_RST  = 15'd5500;

    // products of one tick, stage 1 to stage 2
    typedef struct packed {
        logic signed [PROD_W-1:0] p_now;
        logic signed [PROD_W-1:0] p_prev;
        logic signed [PROD_W-1:0] p_prev2;
        logic                     in_band;
    } t_prod_beat;

endpackage

[rtl/core/heading_pid_speed_command.sv]
// Heading PID speed command, incremental (velocity form) PID on compass heading.
// Pipeline: an accepted heading beat passes through these registers in order
//   (input reg -> multiply reg -> saturating accumulator reg -> output reg).
// Throughput: one beat per cycle unless held by i_out_ready low.
// Reset (i_rst_n low, synchronous): pipeline emptied, error history and accumulator
//   cleared, registers back to their defaults.
module heading_pid_speed_command #(
    parameter int ACCUM_WIDTH = hpsc_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // heading beats
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic [hpsc_pkg::HEAD_W-1:0]          i_heading_tenths,
    // speed command beats
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [hpsc_pkg::SPEED_W-1:0]  o_speed_cmd,
    output logic                                 o_in_band,
    // register writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [hpsc_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hpsc_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // ---------------------------------------------------------------
    // Register file. Writes land any cycle; unknown indexes are dropped.
    // ---------------------------------------------------------------
    logic [hpsc_pkg::SETPT_W-1:0]        r_setpoint;
    logic signed [hpsc_pkg::GAIN_W-1:0]  r_gain_now;
    logic signed [hpsc_pkg::GAIN_W-1:0]  r_gain_prev;
    logic signed [hpsc_pkg::GAIN_W-1:0]  r_gain_prev2;
    logic [hpsc_pkg::BAND_W-1:0]         r_band;
    logic [hpsc_pkg::LIMIT_W-1:0]        r_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_setpoint   <= hpsc_pkg::SETPT_RST;
            r_gain_now   <= hpsc_pkg::GAIN0_RST;
            r_gain_prev  <= hpsc_pkg::GAIN1_RST;
            r_gain_prev2 <= hpsc_pkg::GAIN2_RST;
            r_band       <= hpsc_pkg::BAND_RST;
            r_limit      <= hpsc_pkg::LIMIT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                hpsc_pkg::REG_SETPOINT: begin
                    r_setpoint <= i_cfg_data[hpsc_pkg::SETPT_W-1:0];
                end
                hpsc_pkg::REG_GAIN_NOW: begin
                    r_gain_now <= i_cfg_data;
                end
                hpsc_pkg::REG_GAIN_PREV: begin
                    r_gain_prev <= i_cfg_data;
                end
                hpsc_pkg::REG_GAIN_PREV2: begin
                    r_gain_prev2 <= i_cfg_data;
                end
                hpsc_pkg::REG_BAND: begin
                    r_band <= i_cfg_data[hpsc_pkg::BAND_W-1:0];
                end
                hpsc_pkg::REG_LIMIT: begin
                    r_limit <= i_cfg_data[hpsc_pkg::LIMIT_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Input register: holds the heading beat; each stage has its own
    // valid and takes a new beat whenever it is empty or draining.
    // ---------------------------------------------------------------
    logic                          r_in_valid;
    logic [hpsc_pkg::HEAD_W-1:0]   r_heading;
    logic                          mul_ready;

    assign o_in_ready = !r_in_valid || mul_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_heading <= i_heading_tenths;
        end
    end

    // ---------------------------------------------------------------
    // Stage 1: error, band check, the three Q16 products; error history.
    // ---------------------------------------------------------------
    logic                  mul_valid;
    logic                  acc_ready;
    hpsc_pkg::t_prod_beat  mul_beat;

    hpsc_err_mul u_err_mul (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (r_in_valid),
        .o_ready      (mul_ready),
        .i_heading    (r_heading),
        .i_setpoint   (r_setpoint),
        .i_gain_now   (r_gain_now),
        .i_gain_prev  (r_gain_prev),
        .i_gain_prev2 (r_gain_prev2),
        .i_band       (r_band),
        .o_valid      (mul_valid),
        .i_ready      (acc_ready),
        .o_beat       (mul_beat)
    );

    // ---------------------------------------------------------------
    // Stage 2: u = sat(u_prev + sum of products), saturating at the
    // accumulator width rather than wrapping.
    // ---------------------------------------------------------------
    logic                          acc_valid;
    logic                          out_stage_ready;
    logic signed [ACCUM_WIDTH-1:0] acc_value;
    logic                          acc_in_band;

    hpsc_accum #(
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (mul_valid),
        .o_ready   (acc_ready),
        .i_beat    (mul_beat),
        .o_valid   (acc_valid),
        .i_ready   (out_stage_ready),
        .o_accum   (acc_value),
        .o_in_band (acc_in_band)
    );

    // ---------------------------------------------------------------
    // Stage 3: drop the Q16 fraction toward zero, clamp to +/-limit,
    // result register facing the consumer.
    // ---------------------------------------------------------------
    hpsc_speed_out #(
        .ACCUM_WIDTH (ACCUM_WIDTH)
    ) u_speed_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (acc_valid),
        .o_ready   (out_stage_ready),
        .i_accum   (acc_value),
        .i_in_band (acc_in_band),
        .i_limit   (r_limit),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_speed   (o_speed_cmd),
        .o_in_band (o_in_band)
    );

endmodule

[rtl/core/hpsc_err_mul.sv]
module hpsc_err_mul (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [hpsc_pkg::HEAD_W-1:0]           i_heading,
    input  logic [hpsc_pkg::SETPT_W-1:0]          i_setpoint,
    input  logic signed [hpsc_pkg::GAIN_W-1:0]    i_gain_now,
    input  logic signed [hpsc_pkg::GAIN_W-1:0]    i_gain_prev,
    input  logic signed [hpsc_pkg::GAIN_W-1:0]    i_gain_prev2,
    input  logic [hpsc_pkg::BAND_W-1:0]           i_band,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output hpsc_pkg::t_prod_beat                  o_beat
);

    logic                                r_valid;
    hpsc_pkg::t_prod_beat                r_beat;
    hpsc_pkg::t_prod_beat                n_beat;
    logic signed [hpsc_pkg::ERR_W-1:0]   r_err_last;
    logic signed [hpsc_pkg::ERR_W-1:0]   r_err_prev2;
    logic signed [hpsc_pkg::ERR_W-1:0]   err;
    logic [hpsc_pkg::ERR_W-1:0]          sp_x10;
    logic [hpsc_pkg::ERR_W-1:0]          mag;
    logic                                load;

    // setpoint * 10 = 8x + 2x, in tenths
    assign sp_x10 = (hpsc_pkg::ERR_W)'({i_setpoint, 3'b000})
                  + (hpsc_pkg::ERR_W)'({i_setpoint, 1'b0});
    assign err    = $signed(sp_x10 - (hpsc_pkg::ERR_W)'(i_heading));
    assign mag    = err[hpsc_pkg::ERR_W-1] ? (-err) : err;

    always_comb begin
        n_beat.p_now   = (hpsc_pkg::PROD_W)'(i_gain_now)   * (hpsc_pkg::PROD_W)'(err);
        n_beat.p_prev  = (hpsc_pkg::PROD_W)'(i_gain_prev)  * (hpsc_pkg::PROD_W)'(r_err_last);
        n_beat.p_prev2 = (hpsc_pkg::PROD_W)'(i_gain_prev2) * (hpsc_pkg::PROD_W)'(r_err_prev2);
        n_beat.in_band = (mag <= (hpsc_pkg::ERR_W)'(i_band));
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_err_last  <= '0;
            r_err_prev2 <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_err_prev2 <= r_err_last;
                r_err_last  <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_beat <= n_beat;
        end
    end

    assign o_valid = r_valid;
    assign o_beat  = r_beat;

endmodule

[rtl/core/hpsc_accum.sv]
module hpsc_accum #(
    parameter int ACCUM_WIDTH = hpsc_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  hpsc_pkg::t_prod_beat          i_beat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [ACCUM_WIDTH-1:0] o_accum,
    output logic                          o_in_band
);

    localparam int SUM_W = ((ACCUM_WIDTH > hpsc_pkg::PROD_W + 2) ?
                            ACCUM_WIDTH : hpsc_pkg::PROD_W + 2) + 2;
    localparam logic [ACCUM_WIDTH-1:0] ACC_MAX = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
    localparam logic [ACCUM_WIDTH-1:0] ACC_MIN = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};

    logic                          r_valid;
    logic                          r_in_band;
    logic signed [ACCUM_WIDTH-1:0] r_accum;
    logic signed [ACCUM_WIDTH-1:0] n_accum;
    logic signed [SUM_W-1:0]       sum;
    logic                          ovf;
    logic                          load;

    assign sum = (SUM_W)'(r_accum)
               + (SUM_W)'(i_beat.p_now)
               + (SUM_W)'(i_beat.p_prev)
               + (SUM_W)'(i_beat.p_prev2);

    // out of range when the bits above the accumulator sign differ from it
    assign ovf = (sum[SUM_W-1:ACCUM_WIDTH-1] != {(SUM_W-ACCUM_WIDTH+1){sum[SUM_W-1]}});

    always_comb begin
        if (ovf) begin
            n_accum = sum[SUM_W-1] ? $signed(ACC_MIN) : $signed(ACC_MAX);
        end else begin
            n_accum = sum[ACCUM_WIDTH-1:0];
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_accum <= '0;
        end else begin
            if (o_ready) begin
                r_valid <= i_valid;
            end
            if (load) begin
                r_accum <= n_accum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_in_band <= i_beat.in_band;
        end
    end

    assign o_valid   = r_valid;
    assign o_accum   = r_accum;
    assign o_in_band = r_in_band;

endmodule

[rtl/core/hpsc_speed_out.sv]
module hpsc_speed_out #(
    parameter int ACCUM_WIDTH = hpsc_pkg::ACCUM_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic signed [ACCUM_WIDTH-1:0]        i_accum,
    input  logic                                 i_in_band,
    input  logic [hpsc_pkg::LIMIT_W-1:0]         i_limit,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [hpsc_pkg::SPEED_W-1:0]  o_speed,
    output logic                                 o_in_band
);

    localparam int QW = ACCUM_WIDTH - hpsc_pkg::FRAC_BITS + 1;

    logic                                r_valid;
    logic signed [hpsc_pkg::SPEED_W-1:0] r_speed;
    logic                                r_in_band;
    logic signed [QW-2:0]                q_floor;
    logic signed [QW-1:0]                quot;
    logic signed [QW-1:0]                lim_p;
    logic signed [QW-1:0]                lim_n;
    logic signed [QW-1:0]                clamped;
    logic                                round_up;
    logic                                load;

    // divide by 2^16 toward zero: floor shift, bump negatives with a fraction
    assign q_floor  = i_accum[ACCUM_WIDTH-1:hpsc_pkg::FRAC_BITS];
    assign round_up = i_accum[ACCUM_WIDTH-1] & (|i_accum[hpsc_pkg::FRAC_BITS-1:0]);
    assign quot     = (QW)'(q_floor) + {{(QW-1){1'b0}}, round_up};
    assign lim_p    = (QW)'({1'b0, i_limit});
    assign lim_n    = -lim_p;

    always_comb begin
        if (quot > lim_p) begin
            clamped = lim_p;
        end else if (quot < lim_n) begin
            clamped = lim_n;
        end else begin
            clamped = quot;
        end
    end

    assign o_ready = !r_valid || i_ready;
    assign load    = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_speed   <= clamped[hpsc_pkg::SPEED_W-1:0];
            r_in_band <= i_in_band;
        end
    end

    assign o_valid   = r_valid;
    assign o_speed   = r_speed;
    assign o_in_band = r_in_band;

endmodule
